FILE: sv/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants and the arctangent table for the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TAB_LEN          = 24;
  localparam int ANG_W            = 32;
  localparam int SUM_W            = 34;
  localparam int CW               = 36;
  localparam int SQ_BITS          = 28;
  localparam int SQ_W             = 57;
  localparam int V_W              = 55;

  localparam logic [ANG_W-1:0] HALF_PI_ANG = 32'h4000_0000;
  localparam logic signed [SUM_W-1:0] ONE_Q27 = 34'sd134217728;
  localparam logic [V_W-1:0] ONE_Q54 = 55'd1 << 54;
  localparam logic signed [15:0] PITCH_POS = 16'sh4000;
  localparam logic signed [15:0] PITCH_NEG = -16'sh4000;

  // atan(2^-i), 2^31 = pi
  localparam logic [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

FILE: sv/qte_in_if.sv
// ----------------------------------------------------------------------------
// qte_in_if
// Quaternion input channel, valid/ready with Q1.14 components.
// ----------------------------------------------------------------------------
interface qte_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

FILE: sv/qte_out_if.sv
// ----------------------------------------------------------------------------
// qte_out_if
// Euler angle result channel, valid/ready with binary angles.
// ----------------------------------------------------------------------------
interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic               pitch_clamped;

  modport source(output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                 input ready);
  modport sink(input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
               output ready);
endinterface

FILE: sv/quaternion_to_euler_angles_unit.sv
// throughput: one quaternion per cycle while the skid register is empty, fully pipelined
// depth is set by the 28-stage square root feeding the pitch CORDIC pipeline
// a stalled output is caught by a one-entry skid register, then the pipe holds
// synchronous reset clears the valid bits and the skid entry only
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit
// Z-Y-X Euler angles from a Q1.14 quaternion: products, sums, square root
// for the pitch cosine, three CORDIC arctangents, rounding and output skid.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_unit #(
  parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  qte_in_if.sink    quat,
  qte_out_if.source euler
);
  import qte_pkg::*;

  localparam int OPD   = SQ_BITS + 2;
  localparam int DEPTH = SQ_BITS + 6 + CORDIC_STEPS;

  logic en;
  logic vld [0:DEPTH-1];

  // stage 1: products
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
  // stage 2: sums
  logic signed [SUM_W-1:0] sr, cr, sy, cy, sp;
  // stage 3/4: square and radicand
  logic [V_W-1:0] sq, rad;
  logic signed [27:0] sp_lo;
  logic signed [55:0] sq_full;
  // operand delay line
  logic signed [SUM_W-1:0] d_sr [0:OPD-1];
  logic signed [SUM_W-1:0] d_cr [0:OPD-1];
  logic signed [SUM_W-1:0] d_sy [0:OPD-1];
  logic signed [SUM_W-1:0] d_cy [0:OPD-1];
  logic signed [SUM_W-1:0] d_sp [0:OPD-1];
  logic f_clamp [0:CORDIC_STEPS];
  logic f_neg   [0:CORDIC_STEPS];
  logic [SQ_BITS-1:0] root;
  logic [ANG_W-1:0] ang_roll, ang_pitch, ang_yaw;
  logic clamp_now;
  // output and skid
  logic signed [15:0] o_roll, o_pitch, o_yaw;
  logic o_clamp;
  logic skid_v;
  logic signed [15:0] s_roll, s_pitch, s_yaw;
  logic s_clamp;

  assign en = !skid_v;
  assign quat.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= quat.valid;
      for (int i = 1; i < DEPTH; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= quat.quat_w * quat.quat_x;
      p_yz <= quat.quat_y * quat.quat_z;
      p_xx <= quat.quat_x * quat.quat_x;
      p_yy <= quat.quat_y * quat.quat_y;
      p_wz <= quat.quat_w * quat.quat_z;
      p_xy <= quat.quat_x * quat.quat_y;
      p_zz <= quat.quat_z * quat.quat_z;
      p_wy <= quat.quat_w * quat.quat_y;
      p_zx <= quat.quat_z * quat.quat_x;

      sr <= SUM_W'(p_wx) + SUM_W'(p_yz);
      cr <= ONE_Q27 - (SUM_W'(p_xx) + SUM_W'(p_yy));
      sy <= SUM_W'(p_wz) + SUM_W'(p_xy);
      cy <= ONE_Q27 - (SUM_W'(p_yy) + SUM_W'(p_zz));
      sp <= SUM_W'(p_wy) - SUM_W'(p_zx);

      sq  <= sq_full[V_W-1:0];
      rad <= ONE_Q54 - sq;
    end
  end

  assign sp_lo   = sp[27:0];
  assign sq_full = sp_lo * sp_lo;

  always_ff @(posedge clk) begin
    if (en) begin
      d_sr[0] <= sr;
      d_cr[0] <= cr;
      d_sy[0] <= sy;
      d_cy[0] <= cy;
      d_sp[0] <= sp;
      for (int i = 1; i < OPD; i++) begin
        d_sr[i] <= d_sr[i-1];
        d_cr[i] <= d_cr[i-1];
        d_sy[i] <= d_sy[i-1];
        d_cy[i] <= d_cy[i-1];
        d_sp[i] <= d_sp[i-1];
      end
    end
  end

  qte_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .v_in (rad),
    .root (root)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk   (clk),
    .en    (en),
    .x_in  (CW'(d_cr[OPD-1])),
    .y_in  (CW'(d_sr[OPD-1])),
    .angle (ang_roll)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk   (clk),
    .en    (en),
    .x_in  ({{(CW-SQ_BITS){1'b0}}, root}),
    .y_in  (CW'(d_sp[OPD-1])),
    .angle (ang_pitch)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk   (clk),
    .en    (en),
    .x_in  (CW'(d_cy[OPD-1])),
    .y_in  (CW'(d_sy[OPD-1])),
    .angle (ang_yaw)
  );

  assign clamp_now = (d_sp[OPD-1] >= ONE_Q27) || (d_sp[OPD-1] <= -ONE_Q27);

  always_ff @(posedge clk) begin
    if (en) begin
      f_clamp[0] <= clamp_now;
      f_neg[0]   <= d_sp[OPD-1][SUM_W-1];
      for (int i = 1; i <= CORDIC_STEPS; i++) begin
        f_clamp[i] <= f_clamp[i-1];
        f_neg[i]   <= f_neg[i-1];
      end
      o_roll  <= ang_roll[31:16] + 16'(ang_roll[15]);
      o_yaw   <= ang_yaw[31:16] + 16'(ang_yaw[15]);
      o_clamp <= f_clamp[CORDIC_STEPS];
      if (f_clamp[CORDIC_STEPS]) begin
        o_pitch <= f_neg[CORDIC_STEPS] ? PITCH_NEG : PITCH_POS;
      end else begin
        o_pitch <= ang_pitch[31:16] + 16'(ang_pitch[15]);
      end
    end
  end

  // skid entry holds the older result while the pipe refills the output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (euler.ready) skid_v <= 1'b0;
    end else if (vld[DEPTH-1] && !euler.ready) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[DEPTH-1] && !euler.ready) begin
      s_roll  <= o_roll;
      s_pitch <= o_pitch;
      s_yaw   <= o_yaw;
      s_clamp <= o_clamp;
    end
  end

  assign euler.valid         = skid_v || vld[DEPTH-1];
  assign euler.roll_angle    = skid_v ? s_roll  : o_roll;
  assign euler.pitch_angle   = skid_v ? s_pitch : o_pitch;
  assign euler.yaw_angle     = skid_v ? s_yaw   : o_yaw;
  assign euler.pitch_clamped = skid_v ? s_clamp : o_clamp;

`ifndef ASSERT_OFF
  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(vld[DEPTH-1] && !euler.ready))
    else $error("skid filled without a stalled result");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_v && !euler.ready |=> skid_v && $stable(s_roll) && $stable(s_pitch))
    else $error("skid entry lost while stalled");

  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld[DEPTH-1]) && $stable(o_roll) && $stable(o_yaw))
    else $error("pipeline moved during a stall");

  a_clamp_value: assert property (@(posedge clk) disable iff (rst)
    euler.valid && euler.pitch_clamped |->
      (euler.pitch_angle == PITCH_POS || euler.pitch_angle == PITCH_NEG))
    else $error("clamped pitch is not a quarter turn");
`endif
endmodule

FILE: sv/qte_isqrt.sv
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined floor integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module qte_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [qte_pkg::V_W-1:0]    v_in,
  output logic [qte_pkg::SQ_BITS-1:0] root
);
  import qte_pkg::*;

  logic [SQ_W-1:0] vs [1:SQ_BITS];
  logic [SQ_W-1:0] rs [1:SQ_BITS];

  for (genvar g = 0; g < SQ_BITS; g++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = {{(SQ_W-1){1'b0}}, 1'b1} << (2*(SQ_BITS-1-g));
    logic [SQ_W-1:0] v_cur;
    logic [SQ_W-1:0] r_cur;
    logic [SQ_W-1:0] trial;
    if (g == 0) begin : g_first
      assign v_cur = {{(SQ_W-V_W){1'b0}}, v_in};
      assign r_cur = '0;
    end else begin : g_rest
      assign v_cur = vs[g];
      assign r_cur = rs[g];
    end
    assign trial = r_cur + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v_cur >= trial) begin
          vs[g+1] <= v_cur - trial;
          rs[g+1] <= (r_cur >> 1) + BIT;
        end else begin
          vs[g+1] <= v_cur;
          rs[g+1] <= r_cur >> 1;
        end
      end
    end
  end

  assign root = rs[SQ_BITS][SQ_BITS-1:0];
endmodule

FILE: sv/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC: quarter-turn prerotation stage, then one
// micro-rotation per register stage; returns a 32-bit binary angle.
// ----------------------------------------------------------------------------
module qte_cordic #(
  parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [qte_pkg::CW-1:0] x_in,
  input  logic signed [qte_pkg::CW-1:0] y_in,
  output logic [qte_pkg::ANG_W-1:0]     angle
);
  import qte_pkg::*;

  logic signed [CW-1:0]    xs [0:STEPS];
  logic signed [CW-1:0]    ys [0:STEPS];
  logic [ANG_W-1:0]        zs [0:STEPS];
  logic                    zr [0:STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      zr[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[CW-1]) begin
        if (!y_in[CW-1]) begin
          xs[0] <= y_in;
          ys[0] <= -x_in;
          zs[0] <= HALF_PI_ANG;
        end else begin
          xs[0] <= -y_in;
          ys[0] <= x_in;
          zs[0] <= -HALF_PI_ANG;
        end
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zr[g+1] <= zr[g];
        if (!ys[g][CW-1]) begin
          xs[g+1] <= xs[g] + (ys[g] >>> g);
          ys[g+1] <= ys[g] - (xs[g] >>> g);
          zs[g+1] <= zs[g] + ATAN_TAB[g];
        end else begin
          xs[g+1] <= xs[g] - (ys[g] >>> g);
          ys[g+1] <= ys[g] + (xs[g] >>> g);
          zs[g+1] <= zs[g] - ATAN_TAB[g];
        end
      end
    end
  end

  assign angle = zr[STEPS] ? '0 : zs[STEPS];
endmodule
